// ----- src/dq_pkg.sv -----
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types and codes for the double-ended queue unit: operation and
// status codes, controller states and the controller/datapath link.
// ----------------------------------------------------------------------------
package dq_pkg;

    // Fixed field widths at the block boundary
    localparam int FIELD_W  = 64;
    localparam int OPCODE_W = 3;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_LENGTH     = 3'd4,
        OP_LIST       = 3'd5
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_RESULT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic accept;    // take the operation on the input ports
        logic load_out;  // load the output register
    } t_dq_cmd;

    // Datapath to controller
    typedef struct packed {
        logic more;      // a list request still has entries to present
    } t_dq_stat;

endpackage

// ----- src/dq_ctrl.sv -----
// ----------------------------------------------------------------------------
// dq_ctrl
// Sequencer: takes one operation, waits out the memory read, then presents
// results until the last one has gone.
// ----------------------------------------------------------------------------
module dq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    input  dq_pkg::t_dq_stat i_stat,
    output dq_pkg::t_dq_cmd  o_cmd
);
    import dq_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (!i_out_stall && !i_stat.more) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_stall   = 1'b0;
                o_cmd.accept = i_in_valid;
            end
            S_READ: begin
                o_cmd.load_out = 1'b1;
            end
            S_RESULT: begin
                o_out_valid    = 1'b1;
                o_cmd.load_out = !i_out_stall && i_stat.more;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.accept && o_cmd.load_out))
        else $error("accept and load_out together");

    a_accept_then_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> o_cmd.load_out && !o_out_valid)
        else $error("accepted beat not followed by output load");

    a_no_accept_while_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input open while a result is pending");

endmodule

// ----- src/dq_datapath.sv -----
// ----------------------------------------------------------------------------
// dq_datapath
// Circular store with front/back pointers and count, registered read port,
// list cursor with one-entry prefetch, and the output register.
// ----------------------------------------------------------------------------
module dq_datapath #(
    parameter int DEPTH     = 64,
    parameter int WORD_BITS = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  dq_pkg::t_dq_cmd                i_cmd,
    output dq_pkg::t_dq_stat               o_stat,
    input  logic [dq_pkg::OPCODE_W-1:0]    i_opcode,
    input  logic [dq_pkg::FIELD_W-1:0]     i_entry_key,
    input  logic [dq_pkg::FIELD_W-1:0]     i_entry_value,
    output logic [dq_pkg::FIELD_W-1:0]     o_out_key,
    output logic [dq_pkg::FIELD_W-1:0]     o_out_value,
    output logic [dq_pkg::COUNT_W-1:0]     o_entry_count,
    output logic [dq_pkg::STATUS_W-1:0]    o_status,
    output logic                           o_last
);
    import dq_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int ENT_W = 2 * WORD_BITS;
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

    function automatic logic [PTR_W-1:0] slot_next(input logic [PTR_W-1:0] s);
        slot_next = (s == LAST_SLOT) ? '0 : s + PTR_W'(1);
    endfunction

    function automatic logic [PTR_W-1:0] slot_prev(input logic [PTR_W-1:0] s);
        slot_prev = (s == '0) ? LAST_SLOT : s - PTR_W'(1);
    endfunction

    // key in the upper half, value in the lower half
    logic [ENT_W-1:0] r_mem [DEPTH];
    logic [ENT_W-1:0] r_rd_data;

    logic [PTR_W-1:0] r_front, n_front;
    logic [PTR_W-1:0] r_back, n_back;
    logic [CNT_W-1:0] r_count, n_count;
    logic [PTR_W-1:0] r_cursor, n_cursor;
    logic [CNT_W-1:0] r_left, n_left;     // list entries not yet loaded out
    logic             r_list, n_list;
    logic             r_use_mem, n_use_mem;
    t_status          r_status, n_status;

    logic [WORD_BITS-1:0] r_out_key;
    logic [WORD_BITS-1:0] r_out_value;
    logic [CNT_W-1:0]     r_out_count;
    t_status              r_out_status;
    logic                 r_out_last;

    logic             wr_en;
    logic [PTR_W-1:0] wr_addr;
    logic             rd_en;
    logic [PTR_W-1:0] rd_addr;
    logic             full;
    logic             empty;

    assign full  = (r_count == FULL_CNT);
    assign empty = (r_count == '0);

    always_comb begin
        n_front   = r_front;
        n_back    = r_back;
        n_count   = r_count;
        n_cursor  = r_cursor;
        n_left    = r_left;
        n_list    = r_list;
        n_use_mem = r_use_mem;
        n_status  = r_status;
        wr_en     = 1'b0;
        wr_addr   = r_back;
        rd_en     = 1'b0;
        rd_addr   = r_cursor;
        if (i_cmd.accept) begin
            n_list    = 1'b0;
            n_use_mem = 1'b0;
            n_status  = ST_OK;
            n_left    = '0;
            case (i_opcode)
                OP_PUSH_FRONT: begin
                    if (full) begin
                        n_status = ST_FULL;
                    end else begin
                        n_front = slot_prev(r_front);
                        wr_en   = 1'b1;
                        wr_addr = slot_prev(r_front);
                        n_count = r_count + CNT_W'(1);
                    end
                end
                OP_PUSH_BACK: begin
                    if (full) begin
                        n_status = ST_FULL;
                    end else begin
                        n_back  = slot_next(r_back);
                        wr_en   = 1'b1;
                        wr_addr = r_back;
                        n_count = r_count + CNT_W'(1);
                    end
                end
                OP_POP_FRONT: begin
                    if (empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        rd_en     = 1'b1;
                        rd_addr   = r_front;
                        n_front   = slot_next(r_front);
                        n_count   = r_count - CNT_W'(1);
                        n_use_mem = 1'b1;
                    end
                end
                OP_POP_BACK: begin
                    if (empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        rd_en     = 1'b1;
                        rd_addr   = slot_prev(r_back);
                        n_back    = slot_prev(r_back);
                        n_count   = r_count - CNT_W'(1);
                        n_use_mem = 1'b1;
                    end
                end
                OP_LIST: begin
                    if (empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        rd_en     = 1'b1;
                        rd_addr   = r_front;
                        n_cursor  = slot_next(r_front);
                        n_left    = r_count;
                        n_list    = 1'b1;
                        n_use_mem = 1'b1;
                    end
                end
                default: begin
                    n_status = ST_OK;  // length, and unused codes
                end
            endcase
        end else if (i_cmd.load_out && r_list) begin
            n_left = r_left - CNT_W'(1);
            // prefetch the following entry while this one waits
            if (r_left != CNT_W'(1)) begin
                rd_en    = 1'b1;
                rd_addr  = r_cursor;
                n_cursor = slot_next(r_cursor);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front   <= '0;
            r_back    <= '0;
            r_count   <= '0;
            r_left    <= '0;
            r_list    <= 1'b0;
            r_use_mem <= 1'b0;
            r_status  <= ST_OK;
        end else begin
            r_front   <= n_front;
            r_back    <= n_back;
            r_count   <= n_count;
            r_left    <= n_left;
            r_list    <= n_list;
            r_use_mem <= n_use_mem;
            r_status  <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cursor <= n_cursor;
    end

    // Store: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= {i_entry_key[WORD_BITS-1:0], i_entry_value[WORD_BITS-1:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_key    <= r_use_mem ? r_rd_data[ENT_W-1:WORD_BITS] : '0;
            r_out_value  <= r_use_mem ? r_rd_data[WORD_BITS-1:0] : '0;
            r_out_count  <= r_count;
            r_out_status <= r_status;
            r_out_last   <= !(r_list && (r_left != CNT_W'(1)));
        end
    end

    assign o_stat.more   = r_list && (r_left != '0);
    assign o_out_key     = FIELD_W'(r_out_key);
    assign o_out_value   = FIELD_W'(r_out_value);
    assign o_entry_count = COUNT_W'(r_out_count);
    assign o_status      = r_out_status;
    assign o_last        = r_out_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("count beyond depth");

    a_ptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_front <= LAST_SLOT) && (r_back <= LAST_SLOT))
        else $error("pointer outside store");

    a_left_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_list |-> (r_left <= r_count))
        else $error("list remainder exceeds count");

endmodule

// ----- src/double_ended_queue_unit.sv -----
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// Double-ended queue of key/value entries in a circular store: push and pop
// at either end, length, and a front-to-back listing.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+---------------------------
//  in       | to unit   | i_in_valid / o_in_stall    | opcode, entry_key/value
//  out      | from unit | o_out_valid / i_out_stall  | key, value, count,
//           |           |                            | status, last
//
//  Push, pop, length: each beat passes accept, store read and result, and the
//  result is held for as long as the output is stalled.
//  List of N entries: one entry a cycle while out is not stalled, from the
//  store's registered read port, next entry prefetched while one waits.
//  Reset (synchronous, i_rst_n low) empties the queue; the store is not
//  cleared and needs no clearing pass.
//  Input is stalled from accept until the last result of that beat has gone.
//
module double_ended_queue_unit #(
    parameter int DEPTH     = 64,   // 2 .. 64 entries
    parameter int WORD_BITS = 64    // 8 .. 64 bits held per key and value
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // operation beat
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [dq_pkg::OPCODE_W-1:0]   i_opcode,
    input  logic [dq_pkg::FIELD_W-1:0]    i_entry_key,
    input  logic [dq_pkg::FIELD_W-1:0]    i_entry_value,
    // result beat
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [dq_pkg::FIELD_W-1:0]    o_out_key,
    output logic [dq_pkg::FIELD_W-1:0]    o_out_value,
    output logic [dq_pkg::COUNT_W-1:0]    o_entry_count,
    output logic [dq_pkg::STATUS_W-1:0]   o_status,
    output logic                          o_last
);
    import dq_pkg::*;

    t_dq_cmd  cmd;
    t_dq_stat stat;

    // Sequencer: one operation in flight at a time
    dq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // Store, pointers, list cursor and the output register
    dq_datapath #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_opcode      (i_opcode),
        .i_entry_key   (i_entry_key),
        .i_entry_value (i_entry_value),
        .o_out_key     (o_out_key),
        .o_out_value   (o_out_value),
        .o_entry_count (o_entry_count),
        .o_status      (o_status),
        .o_last        (o_last)
    );

endmodule

// ----- verif/double_ended_queue_unit_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// double_ended_queue_unit_test
// Self-checking bench for the double-ended queue unit. A driver feeds
// operation beats from a backlog, a shadow deque predicts every result beat,
// and a monitor checks each result beat against the oldest prediction.
// ----------------------------------------------------------------------------
module double_ended_queue_unit_test;
    import dq_pkg::*;

    localparam int QDEPTH       = 64;      // matches the unit's default DEPTH
    localparam int RANDOM_OPS   = 400;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 500_000;
    localparam int REPORT_MAX   = 10;

    // opcodes the unit does not define; they must give a plain ok beat
    localparam logic [OPCODE_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_SPARE_7 = 3'd7;

    localparam logic [FIELD_W-1:0] ALL_ONES = '1;
    localparam logic [FIELD_W-1:0] ODD_BITS = {32{2'b01}};
    localparam logic [FIELD_W-1:0] EVN_BITS = {32{2'b10}};

    typedef struct {
        logic [OPCODE_W-1:0] opcode;
        logic [FIELD_W-1:0]  key;
        logic [FIELD_W-1:0]  value;
    } t_dq_op;

    typedef struct {
        logic [FIELD_W-1:0] key;
        logic [FIELD_W-1:0] value;
        logic [COUNT_W-1:0] count;
        t_status            status;
        logic               last;
    } t_dq_result;

    typedef enum {FILLING, DRAINING, MIXING} t_fill_mode;

    // ------------------------------------------------------------------
    // Clock, reset and the unit's ports, inputs known from time zero
    // ------------------------------------------------------------------
    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_in_valid    = 1'b0;
    logic [OPCODE_W-1:0] i_opcode      = '0;
    logic [FIELD_W-1:0]  i_entry_key   = '0;
    logic [FIELD_W-1:0]  i_entry_value = '0;
    logic                i_out_stall   = 1'b0;

    logic                o_in_stall;
    logic                o_out_valid;
    logic [FIELD_W-1:0]  o_out_key;
    logic [FIELD_W-1:0]  o_out_value;
    logic [COUNT_W-1:0]  o_entry_count;
    logic [STATUS_W-1:0] o_status;
    logic                o_last;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    double_ended_queue_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_opcode      (i_opcode),
        .i_entry_key   (i_entry_key),
        .i_entry_value (i_entry_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_key     (o_out_key),
        .o_out_value   (o_out_value),
        .o_entry_count (o_entry_count),
        .o_status      (o_status),
        .o_last        (o_last)
    );

    // ------------------------------------------------------------------
    // Shadow deque. With 64 slots the 6-bit slot pointers wrap by
    // themselves, just as the circular store does.
    // ------------------------------------------------------------------
    logic [FIELD_W-1:0] shadow_keys   [QDEPTH];
    logic [FIELD_W-1:0] shadow_values [QDEPTH];
    logic [5:0]         shadow_front = '0;   // slot of the front entry
    logic [5:0]         shadow_back  = '0;   // slot just past the back entry
    logic [COUNT_W-1:0] shadow_level = '0;

    t_dq_op     op_backlog[$];     // operation beats not yet accepted
    t_dq_result due_results[$];    // result beats predicted, not yet seen

    int op_total        = 1;
    int ops_accepted    = 0;
    int beats_seen      = 0;
    int mismatches      = 0;
    int full_pushes     = 0;
    int empty_hits      = 0;
    int longest_listing = 0;
    int cycles          = 0;

    // Work out the result beats one operation causes and queue them up.
    function automatic void apply_deque_op(t_dq_op op);
        t_dq_result r;
        logic [5:0] slot;
        int         i;
        r.key    = '0;
        r.value  = '0;
        r.count  = '0;
        r.status = ST_OK;
        r.last   = 1'b1;
        case (op.opcode)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
                if (shadow_level == QDEPTH) begin
                    // full: dropped, nothing stored
                    r.status = ST_FULL;
                    full_pushes++;
                end else begin
                    if (op.opcode == OP_PUSH_FRONT) begin
                        shadow_front = shadow_front - 1'b1;
                        slot = shadow_front;
                    end else begin
                        slot = shadow_back;
                        shadow_back = shadow_back + 1'b1;
                    end
                    shadow_keys[slot]   = op.key;
                    shadow_values[slot] = op.value;
                    shadow_level++;
                end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
                if (shadow_level == 0) begin
                    r.status = ST_EMPTY;
                    empty_hits++;
                end else begin
                    if (op.opcode == OP_POP_FRONT) begin
                        slot = shadow_front;
                        shadow_front = shadow_front + 1'b1;
                    end else begin
                        shadow_back = shadow_back - 1'b1;
                        slot = shadow_back;
                    end
                    r.key   = shadow_keys[slot];
                    r.value = shadow_values[slot];
                    shadow_level--;
                end
            end
            OP_LIST: begin
                if (shadow_level == 0) begin
                    r.status = ST_EMPTY;
                    empty_hits++;
                end else begin
                    // one beat per entry, front to back, last on the final one
                    slot = shadow_front;
                    for (i = 0; i < shadow_level; i++) begin
                        r.key   = shadow_keys[slot];
                        r.value = shadow_values[slot];
                        r.count = shadow_level;
                        r.last  = (i == shadow_level - 1);
                        due_results.push_back(r);
                        slot = slot + 1'b1;
                    end
                    if (int'(shadow_level) > longest_listing)
                        longest_listing = int'(shadow_level);
                    return;
                end
            end
            default: ;  // length and the spare codes leave the deque alone
        endcase
        r.count = shadow_level;
        due_results.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // Idling: the run is split in thirds by operations accepted.
    // Sender eager / receiver stalling often, then swapped, then flat out.
    // ------------------------------------------------------------------
    function automatic int idle_phase();
        return (ops_accepted * 3) / op_total;
    endfunction

    function automatic int sender_idle_pct();
        case (idle_phase())
            0:       return 19;
            1:       return 71;
            default: return 0;
        endcase
    endfunction

    function automatic int receiver_stall_pct();
        case (idle_phase())
            0:       return 71;
            1:       return 19;
            default: return 0;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driver: presents the head of the backlog, holds it while stalled,
    // predicts on acceptance.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : driver
        t_dq_op head;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                apply_deque_op(op_backlog.pop_front());
                ops_accepted++;
            end
            if (i_in_valid && o_in_stall) begin
                // beat held: valid and payload stay as they are
            end else if (op_backlog.size() != 0 &&
                         $urandom_range(99) >= sender_idle_pct()) begin
                head = op_backlog[0];
                i_in_valid    <= 1'b1;
                i_opcode      <= head.opcode;
                i_entry_key   <= head.key;
                i_entry_value <= head.value;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each accepted result beat, then picks next stall.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_dq_result want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                beats_seen++;
                if (due_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("%0t: result beat with nothing due: key %h value %h",
                                 $time, o_out_key, o_out_value);
                end else begin
                    want = due_results.pop_front();
                    if (o_out_key !== want.key || o_out_value !== want.value ||
                        o_entry_count !== want.count || o_status !== want.status ||
                        o_last !== want.last) begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX) begin
                            $display("%0t: mismatch (expected/seen) key %h/%h value %h/%h",
                                     $time, want.key, o_out_key, want.value, o_out_value);
                            $display("    count %0d/%0d status %0d/%0d last %0d/%0d",
                                     want.count, o_entry_count, want.status, o_status,
                                     want.last, o_last);
                        end
                    end
                end
            end
            i_out_stall <= ($urandom_range(99) < receiver_stall_pct());
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Run timed out after %0d cycles", CYCLE_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic queue_op(logic [OPCODE_W-1:0] opcode, logic [FIELD_W-1:0] key,
                            logic [FIELD_W-1:0] value);
        t_dq_op op;
        op.opcode = opcode;
        op.key    = key;
        op.value  = value;
        op_backlog.push_back(op);
    endtask

    // mostly random words, with the odd extreme
    function automatic logic [FIELD_W-1:0] pick_word();
        case ($urandom_range(15))
            0:       return '0;
            1:       return ALL_ONES;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    initial begin : stimulus
        int                  level;
        int                  roll;
        int                  mode_hits;
        int                  mixed_left;
        t_fill_mode          mode;
        logic [OPCODE_W-1:0] opcode;

        // Directed: empty-queue cases, spare codes, extreme words, both ends
        queue_op(OP_POP_FRONT, pick_word(), pick_word());
        queue_op(OP_POP_BACK,  pick_word(), pick_word());
        queue_op(OP_LIST,      pick_word(), pick_word());   // empty listing
        queue_op(OP_LENGTH,    pick_word(), pick_word());
        queue_op(OP_SPARE_6,   ALL_ONES,    ALL_ONES);
        queue_op(OP_SPARE_7,   pick_word(), pick_word());
        queue_op(OP_PUSH_FRONT, ALL_ONES, '0);               // front wraps below slot 0
        queue_op(OP_PUSH_BACK,  '0, ALL_ONES);
        queue_op(OP_PUSH_FRONT, ODD_BITS, EVN_BITS);
        queue_op(OP_PUSH_BACK,  EVN_BITS, ODD_BITS);
        queue_op(OP_PUSH_FRONT, pick_word(), pick_word());
        queue_op(OP_LIST,       '0, '0);                     // five entries
        queue_op(OP_LENGTH,     '0, '0);
        queue_op(OP_POP_BACK,   '0, '0);
        queue_op(OP_POP_FRONT,  '0, '0);
        queue_op(OP_POP_BACK,   '0, '0);
        queue_op(OP_POP_FRONT,  '0, '0);
        queue_op(OP_POP_BACK,   '0, '0);                     // last one out
        queue_op(OP_POP_FRONT,  '0, '0);                     // empty again
        queue_op(OP_PUSH_BACK,  pick_word(), pick_word());
        queue_op(OP_POP_FRONT,  '0, '0);

        // Random: fill to full and push past it, drain to empty and pop past
        // it, then a mixed stretch; lists land at random depths on the way.
        level      = 0;
        mode       = FILLING;
        mode_hits  = 0;
        mixed_left = 0;
        repeat (RANDOM_OPS) begin
            roll = $urandom_range(99);
            if (roll < 6) begin
                opcode = OP_LIST;
            end else if (roll < 11) begin
                opcode = OP_LENGTH;
            end else if (roll < 14) begin
                opcode = $urandom_range(1) ? OP_SPARE_6 : OP_SPARE_7;
            end else if (roll < (mode == FILLING ? 88 : mode == DRAINING ? 25 : 57)) begin
                opcode = $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
                if (level == QDEPTH) begin
                    if (mode == FILLING)
                        mode_hits++;
                end else begin
                    level++;
                end
            end else begin
                opcode = $urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK;
                if (level == 0) begin
                    if (mode == DRAINING)
                        mode_hits++;
                end else begin
                    level--;
                end
            end
            queue_op(opcode, pick_word(), pick_word());

            case (mode)
                FILLING: if (mode_hits >= 3) begin
                    mode      = DRAINING;
                    mode_hits = 0;
                end
                DRAINING: if (mode_hits >= 3) begin
                    mode       = MIXING;
                    mode_hits  = 0;
                    mixed_left = 40;
                end
                default: begin
                    mixed_left--;
                    if (mixed_left <= 0)
                        mode = FILLING;
                end
            endcase
        end
        op_total = op_backlog.size();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // every beat sent and every predicted result back
        while (op_backlog.size() != 0 || due_results.size() != 0)
            @(posedge i_clk);
        // catch any stray beats after the last one due
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d deque operations, %0d result beats checked, %0d mismatched.",
                 op_total, beats_seen, mismatches);
        $display("Pushes on full: %0d, pops/lists on empty: %0d, longest listing: %0d.",
                 full_pushes, empty_hits, longest_listing);
        if (mismatches == 0 && due_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
